>>> rtl/mbiq_pkg.sv
// ============================================================================
// Multichannel biquad IIR package
// Shared widths, configuration register indexes and reset values.
// ============================================================================
`default_nettype none

package mbiq_pkg;

    // Fixed field widths
    localparam int COEF_W    = 18;
    localparam int FLUSH_W   = 8;
    localparam int CHAN_W    = 6;
    localparam int CFG_IDX_W = 3;

    // Defaults for the top level parameters
    localparam int CHANNELS_DEF       = 64;
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 16;

    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [FLUSH_W-1:0]       t_flush;
    typedef logic [CHAN_W-1:0]        t_chan;

    // Configuration register map
    localparam t_cfg_idx CFG_B0    = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_B1    = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_B2    = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_A1    = t_cfg_idx'(3);
    localparam t_cfg_idx CFG_A2    = t_cfg_idx'(4);
    localparam t_cfg_idx CFG_FLUSH = t_cfg_idx'(5);

    // Reset values: unity pass-through, flush disabled
    localparam t_coef  B0_RESET    = t_coef'(65536);
    localparam t_coef  COEF_ZERO   = t_coef'(0);
    localparam t_flush FLUSH_RESET = t_flush'(0);

endpackage : mbiq_pkg

`default_nettype wire

>>> rtl/multichannel_biquad_iir_top.sv
// ============================================================================
// Multichannel biquad IIR filter
// Direct-form-I second-order section with per-channel history in one RAM.
// ============================================================================
// Each input transaction carries a channel number and a signed sample; the
// block returns one transaction with the same channel and the filtered value
// y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2, rounded half up from Q2.16
// products and saturated to SAMPLE_BITS. Per-channel history (x1, x2, y1, y2)
// lives in a single synchronous RAM, one entry per channel, read on accept and
// written back at the last pipeline stage. The pipeline is read / multiply /
// sum / round-saturate-writeback. Throughput is one transaction per cycle as
// long as the output is not stalled and no transaction's channel is still in
// the three stages before writeback; such a transaction is stalled until that
// writeback lands. The output register lets the stages ahead of it keep
// filling while a result waits under output stall, so new input keeps flowing
// until those stages are full. Channels at or above CHANNELS filter against
// zero history and touch no state. A stored output whose magnitude is below
// flush_limit is saved as zero; the delivered result is never flushed.
// Configuration is written through a valid/ready port (always ready) and must
// only change while the block is idle. History reads as zero after reset by
// way of a per-channel written flag; there is no clearing pass.
// ============================================================================
`default_nettype none

module multichannel_biquad_iir_top #(
    parameter int CHANNELS       = mbiq_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS    = mbiq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = mbiq_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_valid,
    output      logic                          o_stall,
    input  wire mbiq_pkg::t_chan               i_channel,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    // output channel
    output      logic                          o_valid,
    input  wire logic                          i_stall,
    output      mbiq_pkg::t_chan               o_out_channel,
    output      logic signed [SAMPLE_BITS-1:0] o_filtered,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire mbiq_pkg::t_cfg_idx            i_cfg_index,
    input  wire logic [mbiq_pkg::COEF_W-1:0]   i_cfg_data
);
    import mbiq_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW     = COEF_W + SB;      // one product
    localparam int ACC_W  = PW + 3;           // five products plus rounding bias
    localparam int ENT_W  = 4 * SB;           // {x1, x2, y1, y2}
    localparam logic [ACC_W-1:0] RND_BIAS =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [SB-1:0] SAT_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAT_MIN = {1'b1, {(SB-1){1'b0}}};

    typedef logic signed [SB-1:0] t_smp;
    typedef logic signed [PW-1:0] t_prod;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_coef  r_b0, r_b1, r_b2, r_a1, r_a2;
    t_flush r_flush;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0    <= B0_RESET;
            r_b1    <= COEF_ZERO;
            r_b2    <= COEF_ZERO;
            r_a1    <= COEF_ZERO;
            r_a2    <= COEF_ZERO;
            r_flush <= FLUSH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_B0:    r_b0    <= t_coef'(i_cfg_data);
                CFG_B1:    r_b1    <= t_coef'(i_cfg_data);
                CFG_B2:    r_b2    <= t_coef'(i_cfg_data);
                CFG_A1:    r_a1    <= t_coef'(i_cfg_data);
                CFG_A2:    r_a2    <= t_coef'(i_cfg_data);
                CFG_FLUSH: r_flush <= i_cfg_data[FLUSH_W-1:0];
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: each stage advances when the next one frees up
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_out_valid;
    logic r_in1, r_in2, r_in3;
    t_chan r_ch1, r_ch2, r_ch3;

    logic out_free, rdy3, rdy2, rdy1;
    logic mv1, mv2, mv3;
    logic in_rng, conflict, accept;

    assign out_free = !r_out_valid || !i_stall;
    assign mv3      = r_v3 && out_free;
    assign rdy3     = !r_v3 || out_free;
    assign mv2      = r_v2 && rdy3;
    assign rdy2     = !r_v2 || rdy3;
    assign mv1      = r_v1 && rdy2;
    assign rdy1     = !r_v1 || rdy2;

    assign in_rng = (32'(i_channel) < CHANNELS);

    // Hold a transaction whose channel has not been written back yet
    assign conflict = in_rng && (
        (r_v1 && r_in1 && (r_ch1 == i_channel)) ||
        (r_v2 && r_in2 && (r_ch2 == i_channel)) ||
        (r_v3 && r_in3 && (r_ch3 == i_channel)));

    assign o_stall = !rdy1 || conflict;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= accept;
            if (rdy2) r_v2 <= mv1;
            if (rdy3) r_v3 <= mv2;
            if (out_free) r_out_valid <= mv3;
        end
    end

    // ------------------------------------------------------------------
    // History RAM and per-channel written flags
    // ------------------------------------------------------------------
    logic [ENT_W-1:0] mem [CHANNELS];
    logic [CHANNELS-1:0] r_written;
    logic [ENT_W-1:0] r_rd_data;
    logic r_rd_ok;
    logic [AW-1:0] rd_addr, wr_addr;
    logic wb_en;
    logic [ENT_W-1:0] wb_data;

    assign rd_addr = AW'(i_channel);
    assign wr_addr = AW'(r_ch3);
    assign wb_en   = mv3 && r_in3;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= mem[rd_addr];
        end
        if (wb_en) begin
            mem[wr_addr] <= wb_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (wb_en) begin
            r_written[wr_addr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: history valid, form the five products
    // ------------------------------------------------------------------
    t_smp r_x1s;
    t_smp h_x1, h_x2, h_y1, h_y2;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch1   <= i_channel;
            r_in1   <= in_rng;
            r_x1s   <= i_sample;
            r_rd_ok <= in_rng && r_written[rd_addr];
        end
    end

    // Unwritten or out-of-range history reads as zero
    assign h_x1 = r_rd_ok ? t_smp'(r_rd_data[4*SB-1:3*SB]) : '0;
    assign h_x2 = r_rd_ok ? t_smp'(r_rd_data[3*SB-1:2*SB]) : '0;
    assign h_y1 = r_rd_ok ? t_smp'(r_rd_data[2*SB-1:SB])   : '0;
    assign h_y2 = r_rd_ok ? t_smp'(r_rd_data[SB-1:0])      : '0;

    // ------------------------------------------------------------------
    // Stage 2: sum products with rounding bias
    // ------------------------------------------------------------------
    t_prod r_p0, r_p1, r_p2, r_p3, r_p4;
    t_smp  r_x2s, r_hx1_2, r_hy1_2;

    always_ff @(posedge i_clk) begin
        if (mv1 && rdy2) begin
            r_ch2   <= r_ch1;
            r_in2   <= r_in1;
            r_x2s   <= r_x1s;
            r_hx1_2 <= h_x1;
            r_hy1_2 <= h_y1;
            r_p0    <= t_prod'(r_b0) * t_prod'(r_x1s);
            r_p1    <= t_prod'(r_b1) * t_prod'(h_x1);
            r_p2    <= t_prod'(r_b2) * t_prod'(h_x2);
            r_p3    <= t_prod'(r_a1) * t_prod'(h_y1);
            r_p4    <= t_prod'(r_a2) * t_prod'(h_y2);
        end
    end

    logic signed [ACC_W-1:0] n_acc;
    assign n_acc = ACC_W'(r_p0) + ACC_W'(r_p1) + ACC_W'(r_p2)
                 - ACC_W'(r_p3) - ACC_W'(r_p4) + $signed(RND_BIAS);

    // ------------------------------------------------------------------
    // Stage 3: shift, saturate, flush, write back
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] r_acc;
    t_smp r_x3s, r_hx1_3, r_hy1_3;

    always_ff @(posedge i_clk) begin
        if (mv2 && rdy3) begin
            r_ch3   <= r_ch2;
            r_in3   <= r_in2;
            r_x3s   <= r_x2s;
            r_hx1_3 <= r_hx1_2;
            r_hy1_3 <= r_hy1_2;
            r_acc   <= n_acc;
        end
    end

    logic signed [ACC_W-1:0] shifted;
    logic [ACC_W-SB:0] top_bits;
    logic fits;
    t_smp y_sat, y_store;
    logic signed [SB:0] y_ext;
    logic [SB:0] y_mag;

    assign shifted  = r_acc >>> COEF_FRAC_BITS;
    assign top_bits = shifted[ACC_W-1:SB-1];
    assign fits     = (&top_bits) || !(|top_bits);

    always_comb begin
        if (fits) begin
            y_sat = shifted[SB-1:0];
        end else if (shifted[ACC_W-1]) begin
            y_sat = SAT_MIN;
        end else begin
            y_sat = SAT_MAX;
        end
    end

    // Flush small feedback values to zero in the stored copy only
    assign y_ext   = {y_sat[SB-1], y_sat};
    assign y_mag   = y_ext[SB] ? (SB+1)'(-y_ext) : (SB+1)'(y_ext);
    assign y_store = (y_mag < (SB+1)'(r_flush)) ? '0 : y_sat;

    // New history: x1 <= x, x2 <= x1, y1 <= stored y, y2 <= y1
    assign wb_data = {r_x3s, r_hx1_3, y_store, r_hy1_3};

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mv3) begin
            o_out_channel <= r_ch3;
            o_filtered    <= y_sat;
        end
    end

    assign o_valid = r_out_valid;

endmodule : multichannel_biquad_iir_top

`default_nettype wire

>>> tb/sv/tb.sv
// ============================================================================
// Multichannel biquad IIR testbench
// Drives channel/sample transactions through the filter with random idle and
// stall bursts on both sides, predicts every filtered sample with a local
// direct-form-I model that keeps its own per-channel history, and checks the
// results in order. Coefficient sets change between phases while the block
// is idle.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbiq_pkg::*;

    localparam int     SB             = SAMPLE_BITS_DEF;
    localparam int     FRAC           = COEF_FRAC_BITS_DEF;
    localparam int     NCH            = CHANNELS_DEF;
    localparam longint SAT_HI         = (longint'(1) << (SB - 1)) - 1;
    localparam longint SAT_LO         = -SAT_HI - 1;
    localparam int     LATENCY        = 4;
    localparam int     CYCLE_LIMIT    = 200000;
    localparam int     SQUEEZE_CYCLES = 120;
    localparam int     PHASE_ITEMS    = 140;
    localparam int     PHASES         = 8;

    // Indexes past the register map; writes to them must change nothing
    localparam t_cfg_idx CFG_SPARE_LO = t_cfg_idx'(6);
    localparam t_cfg_idx CFG_SPARE_HI = t_cfg_idx'(7);

    localparam t_coef COEF_MAX = t_coef'(131071);
    localparam t_coef COEF_MIN = t_coef'(-131072);
    localparam t_coef COEF_ONE = t_coef'(65536);
    localparam t_coef COEF_HALF = t_coef'(32768);
    localparam t_flush FLUSH_MAX = t_flush'(255);

    localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB - 1){1'b0}}};

    typedef struct {
        t_chan                 chan;
        logic signed [SB-1:0]  sample;
    } t_sample_txn;

    typedef struct {
        t_chan                 chan;
        logic signed [SB-1:0]  value;
    } t_filtered_txn;

    // ------------------------------------------------------------------------
    // DUT connections, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    t_chan                 i_channel   = '0;
    logic signed [SB-1:0]  i_sample    = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    t_chan                 o_out_channel;
    logic signed [SB-1:0]  o_filtered;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index = '0;
    logic [COEF_W-1:0]     i_cfg_data  = '0;

    multichannel_biquad_iir_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_channel     (i_channel),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_channel (o_out_channel),
        .o_filtered    (o_filtered),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here
    int unsigned cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Filter prediction: coefficients, flush limit and per-channel history
    // ------------------------------------------------------------------------
    t_coef  c_b0      = B0_RESET;
    t_coef  c_b1      = COEF_ZERO;
    t_coef  c_b2      = COEF_ZERO;
    t_coef  c_a1      = COEF_ZERO;
    t_coef  c_a2      = COEF_ZERO;
    t_flush flush_lim = FLUSH_RESET;

    logic signed [SB-1:0] hist_x1 [NCH] = '{default: '0};
    logic signed [SB-1:0] hist_x2 [NCH] = '{default: '0};
    logic signed [SB-1:0] hist_y1 [NCH] = '{default: '0};
    logic signed [SB-1:0] hist_y2 [NCH] = '{default: '0};

    // Run one sample through the channel's section and advance its history.
    // The returned value is never flushed; only the stored feedback copy is.
    function automatic logic signed [SB-1:0] biquad_step(input t_chan ch,
                                                         input logic signed [SB-1:0] x);
        bit                    live;
        longint                x1, x2, y1, y2, acc, y, mag;
        logic signed [SB-1:0]  y_out;
        live = int'(ch) < NCH;
        x1 = live ? longint'(hist_x1[ch]) : 0;
        x2 = live ? longint'(hist_x2[ch]) : 0;
        y1 = live ? longint'(hist_y1[ch]) : 0;
        y2 = live ? longint'(hist_y2[ch]) : 0;
        acc = longint'(c_b0) * longint'(x) + longint'(c_b1) * x1 + longint'(c_b2) * x2
            - longint'(c_a1) * y1 - longint'(c_a2) * y2;
        acc = acc + (longint'(1) << (FRAC - 1));
        y = acc >>> FRAC;
        if (y > SAT_HI) y = SAT_HI;
        if (y < SAT_LO) y = SAT_LO;
        y_out = y[SB-1:0];
        mag = (y < 0) ? -y : y;
        if (live) begin
            hist_x2[ch] = hist_x1[ch];
            hist_x1[ch] = x;
            hist_y2[ch] = hist_y1[ch];
            hist_y1[ch] = (mag < longint'(flush_lim)) ? '0 : y_out;
        end
        return y_out;
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: pops pending transactions, holds a payload until it is
    // taken, and inserts random idle bursts unless the run is quiet
    // ------------------------------------------------------------------------
    t_sample_txn pending_q[$];
    bit          in_fire     = 1'b0;
    bit          quiet       = 1'b0;
    bit          squeeze_req = 1'b0;
    int unsigned send_gap    = 0;

    always @(posedge i_clk) in_fire <= i_valid && !o_stall;

    always @(negedge i_clk) begin : drive_samples
        t_sample_txn nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_fire) begin
            // hold: the block has not taken this transaction yet
        end else if (send_gap != 0) begin
            send_gap = send_gap - 1;
            i_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            // start an idle burst with this cycle; send_gap holds the rest of it
            send_gap = $urandom_range(0, 16);
            i_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
            nxt = pending_q.pop_front();
            i_channel <= nxt.chan;
            i_sample  <= nxt.sample;
            i_valid   <= 1'b1;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Output stall driver: random bursts, plus one long hold-off that lets the
    // pipeline fill up and push back on the input side
    // ------------------------------------------------------------------------
    int unsigned stall_left   = 0;
    int unsigned squeeze_left = 0;
    bit          squeeze_done = 1'b0;

    always @(negedge i_clk) begin : drive_stall
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (squeeze_req && !squeeze_done) begin
            squeeze_done = 1'b1;
            squeeze_left = SQUEEZE_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (squeeze_left != 0) begin
            squeeze_left = squeeze_left - 1;
            i_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 16);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on every accepted input, check every accepted result
    // against the oldest prediction
    // ------------------------------------------------------------------------
    t_filtered_txn filtered_q[$];
    int unsigned   mismatches = 0;

    always @(posedge i_clk) begin : watch
        t_filtered_txn want;
        if (i_rst_n && i_valid && !o_stall) begin
            want.chan  = i_channel;
            want.value = biquad_step(i_channel, i_sample);
            filtered_q.push_back(want);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (filtered_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: channel %0d filtered %0d",
                             o_out_channel, o_filtered);
            end else begin
                want = filtered_q.pop_front();
                if (o_out_channel !== want.chan || o_filtered !== want.value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected channel %0d filtered %0d, got %0d %0d",
                                 want.chan, want.value, o_out_channel, o_filtered);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Configuration and stimulus helpers
    // ------------------------------------------------------------------------
    // Write one register and mirror it into the prediction once it lands
    task automatic cfg_write(input t_cfg_idx idx, input logic [COEF_W-1:0] data);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_B0:    c_b0 = t_coef'(data);
            CFG_B1:    c_b1 = t_coef'(data);
            CFG_B2:    c_b2 = t_coef'(data);
            CFG_A1:    c_a1 = t_coef'(data);
            CFG_A2:    c_a2 = t_coef'(data);
            CFG_FLUSH: flush_lim = data[FLUSH_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_coefs(input t_coef b0, input t_coef b1, input t_coef b2,
                              input t_coef a1, input t_coef a2,
                              input logic [COEF_W-1:0] flush_word);
        cfg_write(CFG_B0, b0);
        cfg_write(CFG_B1, b1);
        cfg_write(CFG_B2, b2);
        cfg_write(CFG_A1, a1);
        cfg_write(CFG_A2, a2);
        cfg_write(CFG_FLUSH, flush_word);
    endtask

    // Pick a set with poles inside the unit circle so the history stays small
    task automatic load_stable(input t_flush lim);
        int a2, a1, a1_span;
        a2 = int'($urandom_range(0, 52000));
        a1_span = (65536 + a2) * 15 / 16;
        a1 = int'($urandom_range(0, 2 * a1_span)) - a1_span;
        load_coefs(COEF_W'(int'($urandom_range(0, 80000)) - 40000),
                   COEF_W'(int'($urandom_range(0, 80000)) - 40000),
                   COEF_W'(int'($urandom_range(0, 80000)) - 40000),
                   COEF_W'(a1), COEF_W'(a2),
                   {(COEF_W - FLUSH_W)'($urandom_range(0, 1023)), lim});
    endtask

    task automatic send(input t_chan ch, input logic signed [SB-1:0] s);
        t_sample_txn t;
        t.chan   = ch;
        t.sample = s;
        pending_q.push_back(t);
    endtask

    // Wait until every transaction is sent and every result has come back
    task automatic drain();
        while (pending_q.size() != 0 || i_valid || filtered_q.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_chan                 ch;
        logic signed [SB-1:0]  s;
        int                    kind;
        int                    r;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: unity pass-through, extremes of both fields
        send(t_chan'(0), SAMPLE_MAX);
        send(t_chan'(63), SAMPLE_MIN);
        send(t_chan'(1), '0);
        send(t_chan'(2), SB'(-1));
        send(t_chan'(0), SB'(1));
        drain();

        // Integrator y = x + y1 with the largest flush limit: a small output
        // is delivered as is but fed back as zero
        cfg_write(CFG_A1, -COEF_ONE);
        cfg_write(CFG_FLUSH, FLUSH_MAX);
        send(t_chan'(5), SB'(100));
        send(t_chan'(5), SB'(0));
        send(t_chan'(5), SB'(300));
        send(t_chan'(5), SB'(0));
        send(t_chan'(5), SB'(-200));
        send(t_chan'(5), SB'(0));
        drain();

        // Half gain: exercise round-half-up on both signs
        load_coefs(COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, FLUSH_RESET);
        send(t_chan'(7), SB'(1));
        send(t_chan'(7), SB'(-1));
        send(t_chan'(7), SB'(3));
        send(t_chan'(7), SB'(-3));
        drain();

        // Extreme coefficients and samples: saturate toward both bounds
        load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, FLUSH_RESET);
        send(t_chan'(10), SAMPLE_MIN);
        send(t_chan'(10), SAMPLE_MAX);
        send(t_chan'(10), SAMPLE_MAX);
        send(t_chan'(10), SAMPLE_MIN);
        send(t_chan'(10), '0);
        drain();

        // Random phases, each with its own coefficient set
        ch = '0;
        for (int p = 0; p < PHASES; p++) begin
            kind = p % 4;
            quiet = (p == 2 || p == PHASES - 1);
            case (kind)
                0: load_stable(t_flush'($urandom_range(1, 255)));
                1: begin
                    load_coefs(t_coef'($urandom), t_coef'($urandom), t_coef'($urandom),
                               t_coef'($urandom), t_coef'($urandom), COEF_W'($urandom));
                    cfg_write(CFG_SPARE_LO, COEF_W'($urandom));
                    cfg_write(CFG_SPARE_HI, COEF_W'($urandom));
                end
                2: load_stable(FLUSH_RESET);
                default: begin
                    if (p == PHASES - 1)
                        load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                                   FLUSH_RESET);
                    else
                        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                                   {(COEF_W - FLUSH_W)'($urandom_range(0, 1023)),
                                    FLUSH_MAX});
                end
            endcase
            // hold the output long enough to back the pipeline up
            if (p == 2) squeeze_req = 1'b1;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // repeat channels often to hit the read-after-write hazard
                r = $urandom_range(0, 7);
                if (r >= 3) ch = t_chan'($urandom_range(0, 63));
                else if (r >= 1) ch = t_chan'($urandom_range(0, 3));
                r = $urandom_range(0, 15);
                if (r == 0) s = SAMPLE_MAX;
                else if (r == 1) s = SAMPLE_MIN;
                else if (kind == 0) s = SB'(int'($urandom_range(0, 1200)) - 600);
                else s = SB'($urandom);
                send(ch, s);
            end
            drain();
        end

        // Let any stray result show up before judging the run
        repeat (4 * LATENCY) @(posedge i_clk);
        if (mismatches == 0 && filtered_q.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
